// File: design/srsp_pkg.sv
// Shared types, constants and palette for the stitch record stream parser.
// No dependencies; every other file in design/ imports this package.
package srsp_pkg;

    // Kind of one result item
    typedef enum logic [1:0] {
        KIND_THREAD = 2'd0,
        KIND_STITCH = 2'd1,
        KIND_END    = 2'd2
    } t_item_kind;

    // Kind of one stitch
    typedef enum logic [1:0] {
        STITCH_NORMAL = 2'd0,
        STITCH_STOP   = 2'd1,
        STITCH_TRIM   = 2'd2
    } t_stitch_kind;

    // Parser phase of the front end
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_COLORS  = 3'd1,
        PH_COUNT   = 3'd2,
        PH_RECORDS = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    // One input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in_item;

    // One result beat
    typedef struct packed {
        t_item_kind          item_kind;
        logic [7:0]          color_index;
        logic [23:0]         color_rgb;
        logic                bad_color;
        logic signed [23:0]  pos_x;
        logic signed [23:0]  pos_y;
        t_stitch_kind        stitch_kind;
        logic                last_of_run;
    } t_result;

    // Command from the front end to the back end: one primary result,
    // optionally followed by an end item caused by the same byte
    typedef struct packed {
        t_item_kind  kind;
        logic        end_after;
        logic [7:0]  data;    // color index for threads, flag byte for stitches
        logic [23:0] raw_x;
        logic [23:0] raw_y;
    } t_cmd;

    // Byte positions inside the header, a record and the color table
    localparam logic [3:0] POS_HEADER_LAST = 4'd3;
    localparam logic [3:0] POS_X_END       = 4'd3;
    localparam logic [3:0] POS_Y_START     = 4'd4;
    localparam logic [3:0] POS_Y_END       = 4'd7;
    localparam logic [3:0] POS_RECORD_LAST = 4'd8;
    localparam logic [4:0] COLORS_LAST     = 5'd15;

    // Color index and coordinate decode constants
    localparam logic [7:0]  MAX_COLOR_INDEX = 8'd15;
    localparam logic [23:0] COORD_MAG_MASK  = 24'h7FFFFF;
    localparam logic [23:0] COORD_NEG_BIAS  = 24'h7FFFFE;
    localparam int          FLAG_STOP_BIT   = 0;
    localparam int          FLAG_TRIM_BIT   = 2;

    // Fixed 16-entry thread palette, red in the top byte
    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h000080;
            4'd2:    rgb = 24'h0000FF;
            4'd3:    rgb = 24'h008080;
            4'd4:    rgb = 24'h00FFFF;
            4'd5:    rgb = 24'h800080;
            4'd6:    rgb = 24'hFF00FF;
            4'd7:    rgb = 24'h800000;
            4'd8:    rgb = 24'hFF0000;
            4'd9:    rgb = 24'h008000;
            4'd10:   rgb = 24'h00FF00;
            4'd11:   rgb = 24'h808000;
            4'd12:   rgb = 24'hFFFF00;
            4'd13:   rgb = 24'h808080;
            4'd14:   rgb = 24'hC0C0C0;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

// File: design/srsp_front.sv
// Front end: tracks the file layout byte by byte and issues result commands.
// Depends on srsp_pkg.
module srsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  srsp_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output srsp_pkg::t_cmd    o_cmd
);
    import srsp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [4:0]  r_colors, n_colors;
    logic [15:0] r_left, n_left;
    logic [23:0] r_x, n_x;
    logic [23:0] r_y, n_y;
    logic [15:0] count_word;
    logic [7:0]  b;

    assign b          = i_item.data_byte;
    assign count_word = {r_left[15:8], b};

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_colors <= '0;
            r_left   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_colors <= n_colors;
            r_left   <= n_left;
        end
    end

    // Hold record coordinate bytes
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
    end

    // Advance the parser on each accepted beat
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_colors    = r_colors;
        n_left      = r_left;
        n_x         = r_x;
        n_y         = r_y;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;
        if (i_accept && r_phase != PH_DONE) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_HEADER_LAST) begin
                        n_pos   = '0;
                        n_phase = PH_COLORS;
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end
                PH_COLORS: begin
                    if (r_pos == 4'd0) begin
                        n_pos = 4'd1;
                    end else begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = KIND_THREAD;
                        o_cmd.data  = b;
                        n_pos       = '0;
                        n_colors    = r_colors + 5'd1;
                        if (r_colors == COLORS_LAST) begin
                            n_phase = PH_COUNT;
                        end
                    end
                end
                PH_COUNT: begin
                    if (r_pos == 4'd0) begin
                        n_left = {b, 8'h00};
                        n_pos  = 4'd1;
                    end else begin
                        n_left = count_word;
                        n_pos  = '0;
                        if (count_word == 16'd0) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = KIND_END;
                            n_phase     = PH_DONE;
                        end else begin
                            n_phase = PH_RECORDS;
                        end
                    end
                end
                PH_RECORDS: begin
                    // shift coordinate bytes in, most significant first
                    if (r_pos < POS_X_END) begin
                        n_x = {r_x[15:0], b};
                    end
                    if (r_pos >= POS_Y_START && r_pos < POS_Y_END) begin
                        n_y = {r_y[15:0], b};
                    end
                    if (r_pos == POS_RECORD_LAST) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = KIND_STITCH;
                        o_cmd.data  = b;
                        o_cmd.raw_x = r_x;
                        o_cmd.raw_y = r_y;
                        n_pos       = '0;
                        n_left      = r_left - 16'd1;
                        if (r_left == 16'd1) begin
                            o_cmd.end_after = 1'b1;
                            n_phase         = PH_DONE;
                        end
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
            // close the pattern on an early end of input
            if (i_item.end_of_input && n_phase != PH_DONE) begin
                n_phase = PH_DONE;
                if (o_cmd_valid) begin
                    o_cmd.end_after = 1'b1;
                end else begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = KIND_END;
                end
            end
        end
    end

endmodule

// File: design/srsp_cmd_fifo.sv
// Short command queue between front and back end, register based.
// Depends on srsp_pkg for the command type.
module srsp_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  srsp_pkg::t_cmd i_wr_data,
    input  logic           i_rd_en,
    output logic           o_full,
    output logic           o_empty,
    output srsp_pkg::t_cmd o_rd_data
);
    import srsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr, do_rd;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Store written beats
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: design/srsp_back.sv
// Back end: expands commands into result beats, decodes palette and coordinates,
// and holds the output register. Depends on srsp_pkg.
module srsp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_empty,
    input  srsp_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output srsp_pkg::t_result o_result
);
    import srsp_pkg::*;

    logic    r_valid, n_valid;
    logic    r_second, n_second;
    t_result r_result, n_result;
    logic    load;
    t_result primary;

    // File's sign rule: values above the positive range wrap onto -8388606..1
    function automatic logic [23:0] decode_coord(input logic [23:0] raw);
        logic [23:0] v;
        if (raw > COORD_MAG_MASK) begin
            v = (raw & COORD_MAG_MASK) - COORD_NEG_BIAS;
        end else begin
            v = raw;
        end
        return v;
    endfunction

    // Build the primary result of the head command
    always_comb begin
        primary           = '0;
        primary.item_kind = i_cmd.kind;
        case (i_cmd.kind)
            KIND_THREAD: begin
                primary.color_index = i_cmd.data;
                primary.bad_color   = (i_cmd.data > MAX_COLOR_INDEX);
                primary.color_rgb   = (i_cmd.data > MAX_COLOR_INDEX) ? 24'h000000
                                      : palette_rgb(i_cmd.data[3:0]);
            end
            KIND_STITCH: begin
                primary.pos_x = decode_coord(i_cmd.raw_x);
                primary.pos_y = decode_coord(i_cmd.raw_y);
                if (i_cmd.data[FLAG_STOP_BIT]) begin
                    primary.stitch_kind = STITCH_STOP;
                end else if (i_cmd.data[FLAG_TRIM_BIT]) begin
                    primary.stitch_kind = STITCH_TRIM;
                end else begin
                    primary.stitch_kind = STITCH_NORMAL;
                end
            end
            default: begin
                primary.item_kind = KIND_END;
            end
        endcase
        primary.last_of_run = !i_cmd.end_after;
    end

    assign load    = !r_valid || i_pop;
    assign o_empty = !r_valid;

    // Load the output register from the head command
    always_comb begin
        n_valid   = r_valid;
        n_second  = r_second;
        n_result  = r_result;
        o_cmd_pop = 1'b0;
        if (load) begin
            if (r_second) begin
                // trailing end item of the same byte
                n_result             = '0;
                n_result.item_kind   = KIND_END;
                n_result.last_of_run = 1'b1;
                n_valid              = 1'b1;
                n_second             = 1'b0;
                o_cmd_pop            = 1'b1;
            end else if (!i_cmd_empty) begin
                n_result = primary;
                n_valid  = 1'b1;
                if (i_cmd.end_after) begin
                    n_second = 1'b1;
                end else begin
                    o_cmd_pop = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    // Hold the waiting result
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_result = r_result;

endmodule

// File: design/stitch_record_stream_parser.sv
// Top level of the stitch record stream parser: front end, command queue, back end.
// Depends on srsp_pkg, srsp_front, srsp_cmd_fifo and srsp_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   input    | push in, full out    | i_item   (data_byte, end_of_input)
//   result   | pop in, empty out    | o_result (one thread, stitch or end item)
//
// One byte is accepted per cycle while full is low; the front end updates its position
// counters in the cycle of acceptance. A result passes the command queue, then the
// output register. A byte that causes two results (a thread or stitch plus the end
// item) stays queued until the end item is loaded. Reset is synchronous and clears all
// control state. full rises only when the command queue fills while pop is held low.
module stitch_record_stream_parser #(
    parameter int CMD_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  srsp_pkg::t_in_item i_item,
    output logic               empty,
    input  logic               pop,
    output srsp_pkg::t_result  o_result
);
    import srsp_pkg::*;

    logic accept;
    logic cmd_valid;
    t_cmd cmd_in;
    t_cmd cmd_head;
    logic cmd_empty;
    logic cmd_pop;

    assign accept = push && !full;

    // Classify incoming bytes
    srsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in)
    );

    // Decouple front and back
    srsp_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (cmd_valid),
        .i_wr_data (cmd_in),
        .i_rd_en   (cmd_pop),
        .o_full    (full),
        .o_empty   (cmd_empty),
        .o_rd_data (cmd_head)
    );

    // Emit result beats
    srsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule
